// ===== rtl/core/hnce_pkg.sv =====
// Package for the HTML numeric character escape unit.
// Holds widths, ASCII codes, the queue entry type and the pass-through check.
// No dependencies.
package hnce_pkg;

  localparam int CP_W        = 21;
  localparam int BYTE_W      = 7;
  localparam int DIG_W       = 4;
  localparam int MAX_DIG     = 7;
  localparam int DIGS_W      = DIG_W * MAX_DIG;
  localparam int NDIG_W      = 3;
  localparam int QUOT_W      = CP_W - 3;
  localparam int FIFO_DEPTH  = 4;

  // v / 10 == (v * RECIP) >> RECIP_SHIFT for every 21-bit v
  localparam int               RECIP_SHIFT = 24;
  localparam logic [CP_W-1:0]  RECIP       = CP_W'(1677722);

  localparam logic [BYTE_W-1:0] CH_QUOT  = BYTE_W'(34);
  localparam logic [BYTE_W-1:0] CH_HASH  = BYTE_W'(35);
  localparam logic [BYTE_W-1:0] CH_AMP   = BYTE_W'(38);
  localparam logic [BYTE_W-1:0] CH_ZERO  = BYTE_W'(48);
  localparam logic [BYTE_W-1:0] CH_SEMI  = BYTE_W'(59);
  localparam logic [BYTE_W-1:0] CH_LT    = BYTE_W'(60);
  localparam logic [BYTE_W-1:0] CH_GT    = BYTE_W'(62);
  localparam logic [CP_W-1:0]   PRINT_LO = CP_W'(32);
  localparam logic [CP_W-1:0]   PRINT_HI = CP_W'(126);

  typedef struct packed {
    logic              esc;
    logic [NDIG_W-1:0] ndig;
    logic [DIGS_W-1:0] data;
  } entry_t;

  function automatic logic passes_through(input logic [CP_W-1:0] c);
    logic [BYTE_W-1:0] b;
    b = c[BYTE_W-1:0];
    return (c >= PRINT_LO) && (c <= PRINT_HI) &&
           (b != CH_QUOT) && (b != CH_AMP) && (b != CH_LT) && (b != CH_GT);
  endfunction

endpackage

// ===== rtl/core/html_numeric_char_escape_unit.sv =====
// HTML numeric character escape unit, top level.
// Instantiates hnce_front, hnce_fifo and hnce_back; depends on hnce_pkg.
//
// Usage:
//   Input channel: drive code_point_i and raise push; a beat is taken at a
//   clock edge with push high and full low. Output channel: while empty is
//   low, out_byte_o/last_byte_o hold the oldest byte; pop high with empty low
//   takes it. last_byte_o marks the final byte of each code point.
//   Printable ASCII other than quote, ampersand, less-than and greater-than
//   gives one byte; everything else gives "&#<decimal>;" (4 to 10 bytes).
// Path: a pass-through beat goes into the queue, then the back end's phase
//   register, then the output stage. Throughput: one pass-through character per
//   cycle while the queue has room and the receiver pops. An escaped value
//   holds the input while it is converted (n decimal digits, one digit per cycle
//   through the divide-by-ten multiplier in the front end while the queue has
//   room) and gives n + 3 bytes, one byte per cycle from the back end while popped.
// The front and back ends are joined by a FifoDepth-entry queue, so the
// input keeps flowing while the back end expands a reference.
// Reset clears the queue, the converter and the output stage; the block is
// ready to accept input as soon as reset ends. When the receiver stops popping, the
// output byte holds and full rises once the queue fills.
module html_numeric_char_escape_unit #(
  parameter int FifoDepth = hnce_pkg::FIFO_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  input  logic [hnce_pkg::CP_W-1:0]   code_point_i,
  output logic                        full,
  output logic                        empty,
  input  logic                        pop,
  output logic [hnce_pkg::BYTE_W-1:0] out_byte_o,
  output logic                        last_byte_o
);

  logic             fifo_full;
  logic             fifo_push;
  logic             fifo_empty;
  logic             fifo_pop;
  hnce_pkg::entry_t fifo_din;
  hnce_pkg::entry_t fifo_dout;

  hnce_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .code_point_i (code_point_i),
    .full_o       (full),
    .fifo_full_i  (fifo_full),
    .fifo_push_o  (fifo_push),
    .fifo_entry_o (fifo_din)
  );

  hnce_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .din_i   (fifo_din),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .dout_o  (fifo_dout)
  );

  hnce_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .fifo_entry_i (fifo_dout),
    .fifo_pop_o   (fifo_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_byte_o   (out_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

// ===== rtl/core/hnce_front.sv =====
// Front end: accepts code points, classifies them and converts escaped
// values to decimal, one digit per cycle while the queue has room. Depends on hnce_pkg.
module hnce_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [hnce_pkg::CP_W-1:0] code_point_i,
  output logic                     full_o,
  input  logic                     fifo_full_i,
  output logic                     fifo_push_o,
  output hnce_pkg::entry_t         fifo_entry_o
);

  logic                            busy_q, busy_d;
  logic [hnce_pkg::CP_W-1:0]       v_q, v_d;
  logic [hnce_pkg::NDIG_W-1:0]     cnt_q, cnt_d;
  logic [hnce_pkg::DIGS_W-1:0]     dig_q, dig_d;

  logic [2*hnce_pkg::CP_W-1:0]     prod;
  logic [hnce_pkg::QUOT_W-1:0]     quot;
  logic [hnce_pkg::CP_W-1:0]       ten_quot;
  logic [hnce_pkg::CP_W-1:0]       rem;
  logic [hnce_pkg::DIGS_W-1:0]     dig_shift;
  logic                            accept;
  logic                            pass;
  logic                            done;

  assign prod      = (2*hnce_pkg::CP_W)'(v_q) * (2*hnce_pkg::CP_W)'(hnce_pkg::RECIP);
  assign quot      = prod[hnce_pkg::RECIP_SHIFT +: hnce_pkg::QUOT_W];
  assign ten_quot  = hnce_pkg::CP_W'({quot, 3'b000}) + hnce_pkg::CP_W'({quot, 1'b0});
  assign rem       = v_q - ten_quot;
  assign dig_shift = {rem[hnce_pkg::DIG_W-1:0],
                      dig_q[hnce_pkg::DIGS_W-1:hnce_pkg::DIG_W]};

  assign full_o = busy_q | fifo_full_i;
  assign accept = push_i & ~full_o;
  assign pass   = hnce_pkg::passes_through(code_point_i);
  assign done   = (quot == '0) ||
                  (cnt_q == hnce_pkg::NDIG_W'(hnce_pkg::MAX_DIG - 1));

  always_comb begin
    busy_d = busy_q;
    v_d    = v_q;
    cnt_d  = cnt_q;
    dig_d  = dig_q;
    fifo_push_o  = 1'b0;
    fifo_entry_o = '0;
    if (busy_q) begin
      fifo_entry_o.esc  = 1'b1;
      fifo_entry_o.ndig = cnt_q + 1'b1;
      fifo_entry_o.data = dig_shift;
      if (!fifo_full_i) begin
        if (done) begin
          fifo_push_o = 1'b1;
          busy_d      = 1'b0;
        end else begin
          v_d   = hnce_pkg::CP_W'(quot);
          cnt_d = cnt_q + 1'b1;
          dig_d = dig_shift;
        end
      end
    end else if (accept) begin
      if (pass) begin
        fifo_push_o       = 1'b1;
        fifo_entry_o.esc  = 1'b0;
        fifo_entry_o.ndig = hnce_pkg::NDIG_W'(1);
        fifo_entry_o.data = hnce_pkg::DIGS_W'(code_point_i[hnce_pkg::BYTE_W-1:0]);
      end else begin
        busy_d = 1'b1;
        v_d    = code_point_i;
        cnt_d  = '0;
        dig_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    cnt_q <= cnt_d;
    dig_q <= dig_d;
  end

endmodule

// ===== rtl/core/hnce_fifo.sv =====
// Short queue between front and back end, register based.
// Depends on hnce_pkg for the entry type.
module hnce_fifo #(
  parameter int Depth = hnce_pkg::FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hnce_pkg::entry_t din_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output hnce_pkg::entry_t dout_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  hnce_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign dout_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue count out of range");

endmodule

// ===== rtl/core/hnce_back.sv =====
// Back end: expands queue entries into output bytes, one beat per cycle while
// the output is taken, into a registered output stage. Depends on hnce_pkg.
module hnce_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fifo_empty_i,
  input  hnce_pkg::entry_t            fifo_entry_i,
  output logic                        fifo_pop_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [hnce_pkg::BYTE_W-1:0] out_byte_o,
  output logic                        last_byte_o
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_PASS, PH_AMP, PH_HASH, PH_DIG, PH_SEMI
  } phase_e;

  phase_e                        phase_q;
  logic [hnce_pkg::DIGS_W-1:0]   data_q;
  logic [hnce_pkg::NDIG_W-1:0]   left_q;
  logic                          out_valid_q;
  logic [hnce_pkg::BYTE_W-1:0]   out_byte_q;
  logic                          last_q;

  logic [hnce_pkg::BYTE_W-1:0]   cur_byte;
  logic                          cur_last;
  logic                          have;
  logic                          advance;
  logic                          load;

  always_comb begin
    cur_byte = hnce_pkg::CH_SEMI;
    cur_last = 1'b0;
    unique case (phase_q)
      PH_PASS: begin
        cur_byte = data_q[hnce_pkg::BYTE_W-1:0];
        cur_last = 1'b1;
      end
      PH_AMP:  cur_byte = hnce_pkg::CH_AMP;
      PH_HASH: cur_byte = hnce_pkg::CH_HASH;
      PH_DIG:  cur_byte = hnce_pkg::CH_ZERO + hnce_pkg::BYTE_W'(
                 data_q[hnce_pkg::DIGS_W-1 -: hnce_pkg::DIG_W]);
      PH_SEMI: cur_last = 1'b1;
      default: cur_last = 1'b0;
    endcase
  end

  assign have       = (phase_q != PH_IDLE);
  assign advance    = ~out_valid_q | pop_i;
  assign load       = advance & (~have | cur_last) & ~fifo_empty_i;
  assign fifo_pop_o = load;

  assign empty_o     = ~out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      data_q      <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      last_q      <= 1'b0;
    end else if (advance) begin
      out_valid_q <= have;
      out_byte_q  <= cur_byte;
      last_q      <= cur_last;
      if (!have || cur_last) begin
        if (load) begin
          phase_q <= fifo_entry_i.esc ? PH_AMP : PH_PASS;
          data_q  <= fifo_entry_i.data;
          left_q  <= fifo_entry_i.ndig;
        end else begin
          phase_q <= PH_IDLE;
        end
      end else begin
        unique case (phase_q)
          PH_AMP:  phase_q <= PH_HASH;
          PH_HASH: phase_q <= PH_DIG;
          PH_DIG: begin
            data_q <= data_q << hnce_pkg::DIG_W;
            left_q <= left_q - 1'b1;
            if (left_q == hnce_pkg::NDIG_W'(1)) begin
              phase_q <= PH_SEMI;
            end
          end
          default: phase_q <= PH_IDLE;
        endcase
      end
    end
  end

  a_dig_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DIG |-> left_q != '0) else $error("digit phase with no digits left");

  a_mid_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !last_q |-> phase_q != PH_IDLE && phase_q != PH_PASS)
    else $error("reference cut short");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop_o |-> !fifo_empty_i) else $error("pop from empty queue");

endmodule
